FILE: src/tccs_pkg.sv
// Package for the text console engine: geometry, actions, sequencer states.
package tccs_pkg;
   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int CELLS = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W = 7;
   localparam int ROW_W = 5;
   localparam int OFS_W = 11;
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   localparam logic [3:0] ACT_CHAR      = 4'd0;
   localparam logic [3:0] ACT_TAB       = 4'd1;
   localparam logic [3:0] ACT_NEWLINE   = 4'd2;
   localparam logic [3:0] ACT_BACKSPACE = 4'd3;
   localparam logic [3:0] ACT_UP        = 4'd4;
   localparam logic [3:0] ACT_DOWN      = 4'd5;
   localparam logic [3:0] ACT_LEFT      = 4'd6;
   localparam logic [3:0] ACT_RIGHT     = 4'd7;
   localparam logic [3:0] ACT_SETPOS    = 4'd8;
   localparam logic [3:0] ACT_CLEAR     = 4'd9;
   localparam logic [3:0] ACT_READ      = 4'd10;

   localparam logic CSR_FG = 1'b0;
   localparam logic CSR_BG = 1'b1;

   typedef enum logic [3:0] {
      ST_INIT,      // clearing pass after reset
      ST_IDLE,
      ST_DISPATCH,  // decide per action
      ST_PUT,       // write a cell at cursor, advance unless backspace
      ST_SETTLE,    // wrap / scroll check
      ST_NL,        // newline second half
      ST_SCR_RD,    // scroll: read source
      ST_SCR_WR,    // scroll: write destination
      ST_BLANK,     // blank last row or whole screen
      ST_RD_WAIT,   // read cell latency
      ST_DONE
   } state_type;
endpackage

FILE: src/text_console_cursor_scroll.sv
// Text console engine: cell store, cursor and sequencer.
// One item at a time: the next beat is taken only once the result has been accepted.
// After reset a clearing pass zeroes the store; no beat is taken until it ends.
module text_console_cursor_scroll (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_action,
   input  logic [7:0]  req_char_code,
   input  logic [6:0]  req_column,
   input  logic [4:0]  req_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_cell_word,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_row,
   output logic [10:0] rsp_cursor_offset,
   output logic        rsp_did_scroll,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [3:0]  csr_write_data
);
   localparam int CW = tccs_pkg::COL_W;
   localparam int RW = tccs_pkg::ROW_W;
   localparam int AW = tccs_pkg::ADDR_W;
   localparam int OFS = tccs_pkg::OFS_W;

   logic [15:0] mem [tccs_pkg::CELLS];
   logic [15:0] rdata_ff;
   logic        we;
   logic [AW-1:0] waddr, raddr;
   logic [15:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   tccs_pkg::state_type state_ff, state_in;
   logic [3:0] fg_ff, bg_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [3:0] act_ff, act_in;
   logic [7:0] ch_ff, ch_in;
   logic [CW-1:0] tcol_ff, tcol_in;
   logic [RW-1:0] trow_ff, trow_in;
   logic [1:0] cnt_ff, cnt_in;       // tab writes left
   logic [AW-1:0] ptr_ff, ptr_in;   // sweep pointer
   logic scr_ff, scr_in;
   logic [15:0] cell_ff, cell_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0] cur_addr, tgt_addr;
   assign cur_addr = AW'(row_ff * tccs_pkg::COLUMNS) + AW'(col_ff);
   assign tgt_addr = AW'(trow_ff * tccs_pkg::COLUMNS) + AW'(tcol_ff);

   function automatic logic [15:0] mk(input logic [3:0] b, input logic [3:0] f,
                                       input logic [7:0] c);
      return {b, f, c};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccs_pkg::ST_INIT;
         fg_ff <= 4'd7;
         bg_ff <= 4'd0;
         col_ff <= '0;
         row_ff <= RW'(1);
         ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         row_ff <= row_in;
         ptr_ff <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            if (csr_index == tccs_pkg::CSR_FG) fg_ff <= csr_write_data;
            else bg_ff <= csr_write_data;
         end
      end
      act_ff <= act_in;
      ch_ff <= ch_in;
      tcol_ff <= tcol_in;
      trow_ff <= trow_in;
      cnt_ff <= cnt_in;
      scr_ff <= scr_in;
      cell_ff <= cell_in;
   end

   always_comb begin
      state_in = state_ff;
      col_in = col_ff;
      row_in = row_ff;
      act_in = act_ff;
      ch_in = ch_ff;
      tcol_in = tcol_ff;
      trow_in = trow_ff;
      cnt_in = cnt_ff;
      ptr_in = ptr_ff;
      scr_in = scr_ff;
      cell_in = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      we = 1'b0;
      waddr = cur_addr;
      wdata = mk(bg_ff, fg_ff, ch_ff);
      raddr = ptr_ff;
      req_ready = 1'b0;
      case (state_ff)
         tccs_pkg::ST_INIT: begin
            we = 1'b1;
            waddr = ptr_ff;
            wdata = '0;
            ptr_in = ptr_ff + AW'(1);
            if (ptr_ff == AW'(tccs_pkg::CELLS - 1)) state_in = tccs_pkg::ST_IDLE;
         end
         tccs_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && req_ready) begin
               act_in = req_action;
               ch_in = req_char_code;
               tcol_in = req_column;
               trow_in = req_row;
               scr_in = 1'b0;
               cell_in = '0;
               cnt_in = 2'd3;
               state_in = tccs_pkg::ST_DISPATCH;
            end
         end
         tccs_pkg::ST_DISPATCH: begin
            state_in = tccs_pkg::ST_DONE;
            case (act_ff)
               tccs_pkg::ACT_CHAR: state_in = tccs_pkg::ST_PUT;
               tccs_pkg::ACT_TAB: begin
                  ch_in = tccs_pkg::SPACE_CHAR;
                  state_in = tccs_pkg::ST_PUT;
               end
               tccs_pkg::ACT_NEWLINE: begin
                  ch_in = '0;
                  state_in = tccs_pkg::ST_PUT;
               end
               tccs_pkg::ACT_BACKSPACE, tccs_pkg::ACT_LEFT: begin
                  if (col_ff != '0 || row_ff != '0) begin
                     if (col_ff == '0) begin
                        col_in = CW'(tccs_pkg::COLUMNS - 1);
                        row_in = row_ff - RW'(1);
                     end else begin
                        col_in = col_ff - CW'(1);
                     end
                     if (act_ff == tccs_pkg::ACT_BACKSPACE) begin
                        ch_in = '0;
                        cnt_in = 2'd0;
                        act_in = tccs_pkg::ACT_LEFT; // write only, no advance
                        state_in = tccs_pkg::ST_PUT;
                     end
                  end
               end
               tccs_pkg::ACT_UP: if (row_ff != '0) row_in = row_ff - RW'(1);
               tccs_pkg::ACT_DOWN: begin
                  row_in = row_ff + RW'(1);
                  state_in = tccs_pkg::ST_SETTLE;
               end
               tccs_pkg::ACT_RIGHT: begin
                  col_in = col_ff + CW'(1);
                  state_in = tccs_pkg::ST_SETTLE;
               end
               tccs_pkg::ACT_SETPOS: begin
                  col_in = tcol_ff;
                  row_in = trow_ff;
                  state_in = tccs_pkg::ST_SETTLE;
               end
               tccs_pkg::ACT_CLEAR: begin
                  ptr_in = '0;
                  state_in = tccs_pkg::ST_BLANK;
               end
               tccs_pkg::ACT_READ: begin
                  raddr = tgt_addr;
                  state_in = tccs_pkg::ST_RD_WAIT;
               end
               default: state_in = tccs_pkg::ST_DONE;
            endcase
         end
         tccs_pkg::ST_PUT: begin
            we = 1'b1;
            if (act_ff == tccs_pkg::ACT_LEFT) begin
               state_in = tccs_pkg::ST_DONE;
            end else begin
               col_in = col_ff + CW'(1);
               state_in = tccs_pkg::ST_SETTLE;
            end
         end
         tccs_pkg::ST_SETTLE: begin
            if (32'(col_ff) >= tccs_pkg::COLUMNS) begin
               col_in = '0;
               // a row already past the end stays there and scrolls next
               if (32'(row_ff) < tccs_pkg::ROWS) row_in = row_ff + RW'(1);
            end else if (32'(row_ff) >= tccs_pkg::ROWS) begin
               scr_in = 1'b1;
               row_in = RW'(tccs_pkg::ROWS - 1);
               col_in = '0;
               ptr_in = AW'(2 * tccs_pkg::COLUMNS);
               state_in = tccs_pkg::ST_SCR_RD;
            end else if (act_ff == tccs_pkg::ACT_TAB && cnt_ff != 2'd0) begin
               cnt_in = cnt_ff - 2'd1;
               state_in = tccs_pkg::ST_PUT;
            end else if (act_ff == tccs_pkg::ACT_NEWLINE) begin
               state_in = tccs_pkg::ST_NL;
            end else begin
               state_in = tccs_pkg::ST_DONE;
            end
         end
         tccs_pkg::ST_NL: begin
            col_in = '0;
            row_in = row_ff + RW'(1);
            act_in = tccs_pkg::ACT_DOWN;
            state_in = tccs_pkg::ST_SETTLE;
         end
         tccs_pkg::ST_SCR_RD: begin
            raddr = ptr_ff;
            state_in = tccs_pkg::ST_SCR_WR;
         end
         tccs_pkg::ST_SCR_WR: begin
            we = 1'b1;
            waddr = ptr_ff - AW'(tccs_pkg::COLUMNS);
            wdata = rdata_ff;
            ptr_in = ptr_ff + AW'(1);
            if (ptr_ff == AW'(tccs_pkg::CELLS - 1)) begin
               ptr_in = AW'((tccs_pkg::ROWS - 1) * tccs_pkg::COLUMNS);
               state_in = tccs_pkg::ST_BLANK;
            end else begin
               state_in = tccs_pkg::ST_SCR_RD;
            end
         end
         tccs_pkg::ST_BLANK: begin
            we = 1'b1;
            waddr = ptr_ff;
            wdata = mk(bg_ff, fg_ff, 8'h00);
            ptr_in = ptr_ff + AW'(1);
            if (ptr_ff == AW'(tccs_pkg::CELLS - 1)) state_in = tccs_pkg::ST_SETTLE;
            if (act_ff == tccs_pkg::ACT_CLEAR && ptr_ff == AW'(tccs_pkg::CELLS - 1))
               state_in = tccs_pkg::ST_DONE;
         end
         tccs_pkg::ST_RD_WAIT: begin
            if (32'(tcol_ff) < tccs_pkg::COLUMNS && 32'(trow_ff) < tccs_pkg::ROWS)
               cell_in = rdata_ff;
            state_in = tccs_pkg::ST_DONE;
         end
         tccs_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = tccs_pkg::ST_IDLE;
         end
         default: state_in = tccs_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_word = cell_ff;
   assign rsp_cursor_column = col_ff;
   assign rsp_cursor_row = row_ff;
   assign rsp_cursor_offset = OFS'(cur_addr);
   assign rsp_did_scroll = scr_ff;
endmodule
